// File: src/lcdts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdts_pkg: shared types and constants for the LCD line timing block
// Holds the mode codes, the timing constants and the structs that carry one
// tick, one result and the timing state between modules.
// ----------------------------------------------------------------------------
package lcdts_pkg;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	localparam logic [8:0] DOT_STEP      = 9'd4;
	localparam logic [8:0] DOT_WRAP      = 9'd456;
	localparam logic [8:0] DOT_POWER_ON  = 9'd452;
	localparam logic [8:0] DOT_OAM       = 9'd4;
	localparam logic [8:0] DOT_DRAW      = 9'd84;
	localparam logic [8:0] DRAW_END_BASE = 9'd256;
	localparam logic [8:0] DRAW_END_MID  = 9'd260;
	localparam logic [8:0] DRAW_END_LONG = 9'd264;
	localparam logic [7:0] LINE_LAST     = 8'd153;
	localparam logic [7:0] LINE_VBLANK   = 8'd144;
	localparam logic [7:0] LINE_LAST_VIS = 8'd143;

	typedef struct packed {
		logic       display_enable;
		logic [2:0] fine_scroll_x;
		logic [7:0] compare_line;
		logic [7:0] window_top;
		logic [3:0] source_enables;
	} tick_t;

	typedef struct packed {
		logic       powered;
		logic [8:0] dot_count;
		logic [7:0] line_count;
		mode_t      mode;
		logic       match_flag;
		logic       forced_zero;
		logic [7:0] previous_line;
		logic       previous_signal;
		logic [7:0] window_latch;
	} timing_t;

	typedef struct packed {
		logic [7:0] line_number;
		logic [1:0] display_mode;
		logic       compare_match;
		logic       vblank_request;
		logic       status_request;
		logic       render_start;
		logic       frame_done;
		logic       frame_clear;
		logic       window_restart;
		logic [7:0] window_top_latched;
	} result_t;

endpackage
`default_nettype wire

// File: src/lcdts_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdts_step: next-state and result logic for one tick
// Takes the current timing state and one tick, and gives the state after the
// tick together with the result that the tick produces.
// ----------------------------------------------------------------------------
module lcdts_step (
	input  var lcdts_pkg::timing_t cur,
	input  var lcdts_pkg::tick_t   tick,
	output lcdts_pkg::timing_t     nxt,
	output lcdts_pkg::result_t     res
);
	import lcdts_pkg::*;

	logic [8:0] draw_end;
	logic [8:0] dot_inc;

	// Approximate end of drawing, lengthened by the fine scroll.
	always_comb begin
		if (tick.fine_scroll_x == 3'd0) begin
			draw_end = DRAW_END_BASE;
		end else if (tick.fine_scroll_x <= 3'd4) begin
			draw_end = DRAW_END_MID;
		end else begin
			draw_end = DRAW_END_LONG;
		end
	end

	always_comb begin
		logic sig;
		logic vblank_req;
		logic render;
		logic done;
		logic clear;
		logic restart;
		nxt        = cur;
		sig        = 1'b0;
		vblank_req = 1'b0;
		render     = 1'b0;
		done       = 1'b0;
		clear      = 1'b0;
		restart    = 1'b0;
		dot_inc    = '0;

		if (tick.display_enable != cur.powered) begin
			nxt.powered = tick.display_enable;
			if (tick.display_enable) begin
				nxt.dot_count = DOT_POWER_ON;
				nxt.mode      = MODE_VBLANK;
			end else begin
				nxt.line_count      = '0;
				nxt.mode            = MODE_HBLANK;
				nxt.previous_signal = 1'b0;
				clear               = 1'b1;
			end
		end

		if (nxt.powered) begin
			dot_inc       = nxt.dot_count + DOT_STEP;
			nxt.dot_count = dot_inc;

			// Line 153 is held for a single tick before line 0.
			if (nxt.line_count == LINE_LAST) begin
				nxt.line_count = '0;
			end else if (nxt.dot_count == DOT_WRAP) begin
				nxt.dot_count = '0;
				if (nxt.line_count == 8'd0 && nxt.mode == MODE_VBLANK) begin
					nxt.mode         = MODE_HBLANK;
					nxt.window_latch = tick.window_top;
					restart          = 1'b1;
				end else begin
					nxt.line_count = nxt.line_count + 8'd1;
				end
			end

			// A line change forces the match low for one tick.
			if (nxt.forced_zero) begin
				nxt.match_flag  = (tick.compare_line == nxt.previous_line);
				nxt.forced_zero = 1'b0;
			end else if (nxt.line_count != nxt.previous_line) begin
				nxt.match_flag    = 1'b0;
				nxt.forced_zero   = 1'b1;
				nxt.previous_line = nxt.line_count;
			end else begin
				nxt.match_flag    = (tick.compare_line == nxt.line_count);
				nxt.previous_line = nxt.line_count;
			end

			if ((nxt.line_count == 8'd0 && nxt.mode != MODE_VBLANK) ||
			    (nxt.line_count >= 8'd1 && nxt.line_count <= LINE_LAST_VIS)) begin
				if (nxt.dot_count == DOT_OAM) begin
					nxt.mode = MODE_OAM;
				end else if (nxt.dot_count == DOT_DRAW) begin
					nxt.mode = MODE_DRAW;
					render   = 1'b1;
				end else if (nxt.dot_count == draw_end) begin
					nxt.mode = MODE_HBLANK;
				end
			end else if (nxt.line_count == LINE_VBLANK) begin
				if (nxt.dot_count == DOT_OAM) begin
					vblank_req = 1'b1;
					nxt.mode   = MODE_VBLANK;
					sig        = tick.source_enables[2];
					done       = 1'b1;
				end
			end

			if (tick.source_enables[0] && nxt.mode == MODE_HBLANK) sig = 1'b1;
			if (tick.source_enables[1] && nxt.mode == MODE_VBLANK) sig = 1'b1;
			if (tick.source_enables[2] && nxt.mode == MODE_OAM) sig = 1'b1;
			if (tick.source_enables[3] && nxt.match_flag) sig = 1'b1;
			res.status_request  = sig && !nxt.previous_signal;
			nxt.previous_signal = sig;
		end else begin
			res.status_request = 1'b0;
		end

		res.line_number        = nxt.line_count;
		res.display_mode       = nxt.mode;
		res.compare_match      = nxt.match_flag;
		res.vblank_request     = vblank_req;
		res.render_start       = render;
		res.frame_done         = done;
		res.frame_clear        = clear;
		res.window_restart     = restart;
		res.window_top_latched = nxt.window_latch;
	end

endmodule
`default_nettype wire

// File: src/lcd_line_timing_stat_irq_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_line_timing_stat_irq_top: LCD scanline timing and status interrupts
// Every input transfer is one machine-cycle tick carrying the display enable,
// fine scroll, line compare value, window Y and interrupt source enables.
// Every tick yields exactly one result transfer: the line number, mode and
// compare flag as held after the tick, the interrupt and frame pulses, and
// the window Y latched for the current frame.
// An input transfer is first captured in the input register; the timing
// state and the result register then update together when the tick advances.
// Throughput is one tick per cycle while the receiver takes results, set by
// the single pass of next-state logic between the input and result registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more tick, after which in_ready drops until the result
// is taken. No tick is lost or repeated.
// Reset clears the timing state to display off, line 0, mode 0, and empties
// both registers.
// ----------------------------------------------------------------------------
module lcd_line_timing_stat_irq_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        display_enable,
	input  wire  [2:0] fine_scroll_x,
	input  wire  [7:0] compare_line,
	input  wire  [7:0] window_top,
	input  wire  [3:0] source_enables,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] line_number,
	output logic [1:0] display_mode,
	output logic       compare_match,
	output logic       vblank_request,
	output logic       status_request,
	output logic       render_start,
	output logic       frame_done,
	output logic       frame_clear,
	output logic       window_restart,
	output logic [7:0] window_top_latched
);
	import lcdts_pkg::*;

	logic    valid_s1;
	tick_t   tick_s1;
	timing_t timing_q;
	timing_t timing_next;
	result_t res_next;
	result_t res_q;
	logic    advance;

	// The tick in the input register moves on whenever the result register
	// is empty or its contents are being transferred this cycle.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The tick payload needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1 <= '{display_enable: display_enable,
			             fine_scroll_x:  fine_scroll_x,
			             compare_line:   compare_line,
			             window_top:     window_top,
			             source_enables: source_enables};
		end
	end

	lcdts_step u_step (
		.cur  (timing_q),
		.tick (tick_s1),
		.nxt  (timing_next),
		.res  (res_next)
	);

	// Timing state advances exactly once per tick, in tick order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q <= '{powered: 1'b0, dot_count: '0, line_count: '0,
			              mode: MODE_HBLANK, match_flag: 1'b0, forced_zero: 1'b0,
			              previous_line: '0, previous_signal: 1'b0,
			              window_latch: '0};
		end else if (advance) begin
			timing_q <= timing_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign line_number        = res_q.line_number;
	assign display_mode       = res_q.display_mode;
	assign compare_match      = res_q.compare_match;
	assign vblank_request     = res_q.vblank_request;
	assign status_request     = res_q.status_request;
	assign render_start       = res_q.render_start;
	assign frame_done         = res_q.frame_done;
	assign frame_clear        = res_q.frame_clear;
	assign window_restart     = res_q.window_restart;
	assign window_top_latched = res_q.window_top_latched;

endmodule
`default_nettype wire
